// ===== hdl/pip_pkg.sv =====
package pip_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int MAX_VERTICES = 64;
  localparam int ADDR_WIDTH   = $clog2(MAX_VERTICES);
  localparam int COUNT_WIDTH  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
  localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [1:0] op;
    coord_t     coord_x;
    coord_t     coord_y;
  } in_beat_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } out_beat_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    coord_t    x;
    coord_t    y;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

endpackage

// ===== hdl/pip_front.sv =====
module pip_front
  import pip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic hold_valid;
  cmd_t hold;
  cmd_t decoded;
  logic keep;

  always_comb begin
    decoded.x = in_data.coord_x;
    decoded.y = in_data.coord_y;
    keep      = 1'b1;
    unique case (in_data.op)
      OP_CLEAR:  decoded.kind = CMD_CLEAR;
      OP_APPEND: decoded.kind = CMD_APPEND;
      OP_QUERY:  decoded.kind = CMD_QUERY;
      default: begin
        decoded.kind = CMD_CLEAR;
        keep         = 1'b0;
      end
    endcase
  end

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= keep;
      hold       <= decoded;
    end else if (hold_valid && cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/pip_fifo.sv =====
module pip_fifo
  import pip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t                  entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wptr;
  logic [QPTR_WIDTH-1:0] rptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  push;
  logic                  pop;

  assign push_ready = count != QCNT_WIDTH'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pip_back.sv =====
module pip_back
  import pip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

  state_t state;

  vertex_t vmem [MAX_VERTICES];
  vertex_t rdata;

  logic [COUNT_WIDTH-1:0] vcount;
  logic [COUNT_WIDTH-1:0] step;
  logic [ADDR_WIDTH-1:0]  rd_addr;
  logic                   issuing;
  logic                   wr_en;
  coord_t                 px;
  coord_t                 py;
  logic                   degen;
  logic                   parity;

  // edge pipeline
  logic    v1, first1;
  vertex_t prev;
  logic    v2, pass2, neg2;
  logic signed [DIFF_WIDTH-1:0] dxp2, dy2, dyp2, dx2;
  logic    v3, pass3, neg3;
  logic signed [PROD_WIDTH-1:0] lhs3, rhs3;

  coord_t ylo, yhi, xhi;
  logic   pass1;
  logic signed [DIFF_WIDTH-1:0] dxp1, dy1, dyp1, dx1;
  logic   cross3;

  assign cmd_ready = (state == ST_IDLE);
  assign wr_en     = (state == ST_IDLE) && cmd_valid && (cmd.kind == CMD_APPEND)
                     && (vcount < COUNT_WIDTH'(MAX_VERTICES));
  assign rd_addr   = (step == vcount) ? '0 : step[ADDR_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[vcount[ADDR_WIDTH-1:0]] <= '{x: cmd.x, y: cmd.y};
    end
    if (issuing) begin
      rdata <= vmem[rd_addr];
    end
  end

  // edge from prev (x1,y1) to rdata (x2,y2)
  always_comb begin
    ylo   = (prev.y < rdata.y) ? prev.y : rdata.y;
    yhi   = (prev.y < rdata.y) ? rdata.y : prev.y;
    xhi   = (prev.x < rdata.x) ? rdata.x : prev.x;
    pass1 = (py > ylo) && (py <= yhi) && !(px > xhi);
    dxp1  = DIFF_WIDTH'(px) - DIFF_WIDTH'(prev.x);
    dy1   = DIFF_WIDTH'(rdata.y) - DIFF_WIDTH'(prev.y);
    dyp1  = DIFF_WIDTH'(py) - DIFF_WIDTH'(prev.y);
    dx1   = DIFF_WIDTH'(rdata.x) - DIFF_WIDTH'(prev.x);
    cross3 = neg3 ? (lhs3 >= rhs3) : (lhs3 <= rhs3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= '0;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end

      v1     <= issuing;
      first1 <= issuing && (step == '0);
      if (v1) begin
        prev <= rdata;
      end
      v2    <= v1 && !first1;
      pass2 <= pass1;
      neg2  <= dy1[DIFF_WIDTH-1];
      dxp2  <= dxp1;
      dy2   <= dy1;
      dyp2  <= dyp1;
      dx2   <= dx1;
      v3    <= v2;
      pass3 <= pass2;
      neg3  <= neg2;
      lhs3  <= dxp2 * dy2;
      rhs3  <= dyp2 * dx2;
      if (v3 && pass3 && cross3) begin
        parity <= !parity;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              CMD_CLEAR: vcount <= '0;
              CMD_APPEND: begin
                if (vcount < COUNT_WIDTH'(MAX_VERTICES)) begin
                  vcount <= vcount + 1'b1;
                end
              end
              CMD_QUERY: begin
                px     <= cmd.x;
                py     <= cmd.y;
                parity <= 1'b0;
                step   <= '0;
                if (vcount < COUNT_WIDTH'(3)) begin
                  degen <= 1'b1;
                  state <= ST_RESULT;
                end else begin
                  degen   <= 1'b0;
                  issuing <= 1'b1;
                  state   <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (issuing) begin
            step <= step + 1'b1;
            if (step == vcount) begin
              issuing <= 1'b0;
            end
          end else if (!v1 && !v2 && !v3) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.inside_res <= parity && !degen;
            out_data.degenerate <= degen;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/point_in_polygon_test.sv =====
// A query holds the back end through the edge walk, which reads one vertex per cycle
//   over the single vertex memory read port, and until its result beat is registered;
//   a query on under three vertices skips the walk and is answered as degenerate.
// Clear and append leave the back end idle and ready for the next command.
// Reset: synchronous, clears the vertex count and all queues; vertex memory is not cleared.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  pip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  pip_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  pip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pip_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_GAP       = 10;
  localparam int DRAIN_CYCLES  = MAX_VERTICES + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BEATS  = 1150;

  localparam int MODE_FULL    = 0;
  localparam int MODE_TINY    = 1;
  localparam int MODE_EXTREME = 2;
  localparam int MODE_MID     = 3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_off_cycles = 0;

  // polygon as the block should hold it
  coord_t    poly_x[MAX_VERTICES];
  coord_t    poly_y[MAX_VERTICES];
  int        poly_count = 0;
  out_beat_t expected_verdicts[$];

  int mismatch_count  = 0;
  int idle_cycles     = 0;
  int queries_seen    = 0;
  int inside_seen     = 0;
  int degenerate_seen = 0;
  int appends_dropped = 0;
  int ignored_beats   = 0;

  point_in_polygon_test i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit edge_flips(longint px, longint py, longint ax, longint ay,
                                    longint bx, longint by);
    longint ylo, yhi, xhi, dy, lhs, rhs;
    ylo = (ay < by) ? ay : by;
    yhi = (ay < by) ? by : ay;
    xhi = (ax < bx) ? bx : ax;
    if (!(py > ylo && py <= yhi)) return 1'b0;
    if (px > xhi) return 1'b0;
    dy  = by - ay;
    lhs = (px - ax) * dy;
    rhs = (py - ay) * (bx - ax);
    return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  function automatic out_beat_t ray_cast_verdict(coord_t px, coord_t py);
    out_beat_t v;
    int i, j;
    v = '0;
    if (poly_count < 3) begin
      v.degenerate = 1'b1;
      return v;
    end
    for (i = 0; i < poly_count; i++) begin
      j = (i + 1 == poly_count) ? 0 : i + 1;
      if (edge_flips(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
        v.inside_res = ~v.inside_res;
    end
    return v;
  endfunction

  function automatic void track_beat(in_beat_t b);
    case (b.op)
      OP_CLEAR: poly_count = 0;
      OP_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = b.coord_x;
          poly_y[poly_count] = b.coord_y;
          poly_count++;
        end else begin
          appends_dropped++;
        end
      end
      OP_QUERY: begin
        expected_verdicts.push_back(ray_cast_verdict(b.coord_x, b.coord_y));
        queries_seen++;
      end
      default: ignored_beats++;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing pending, inside_res", out_data.inside_res, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.inside_res !== want.inside_res)
            report_mismatch("inside_res", out_data.inside_res, want.inside_res);
          if (out_data.degenerate !== want.degenerate)
            report_mismatch("degenerate", out_data.degenerate, want.degenerate);
          inside_seen     += want.inside_res;
          degenerate_seen += want.degenerate;
        end
      end
      if (in_valid && in_ready) track_beat(in_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("point_in_polygon_test regression: fail");
        $finish;
      end
    end
  end

  initial begin : receiver
    int wait_n;
    @(posedge clk);
    forever begin
      wait_n = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_off_cycles > 0) begin
        wait_n = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  task automatic send_beat(input logic [1:0] op, input coord_t x, input coord_t y);
    in_beat_t beat;
    int gap;
    beat.op      = op;
    beat.coord_x = x;
    beat.coord_y = y;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      MODE_TINY: return coord_t'(int'($urandom_range(0, 12)) - 6);
      MODE_MID:  return coord_t'(int'($urandom_range(0, 400)) - 200);
      MODE_EXTREME: begin
        case ($urandom_range(0, 7))
          0: return coord_t'(-32768);
          1: return coord_t'(-32767);
          2: return coord_t'(-1);
          3: return coord_t'(0);
          4: return coord_t'(1);
          5: return coord_t'(32766);
          6: return coord_t'(32767);
          default: return coord_t'($urandom);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic test_degenerate_polygons();
    send_beat(OP_QUERY, 16'sd0, 16'sd0);
    send_beat(OP_APPEND, -16'sd32768, -16'sd32768);
    send_beat(OP_QUERY, -16'sd32768, -16'sd32768);
    send_beat(OP_APPEND, 16'sd32767, 16'sd32767);
    send_beat(OP_QUERY, 16'sd0, 16'sd0);
    send_beat(OP_CLEAR, 16'sd32767, -16'sd32768);
    send_beat(OP_QUERY, 16'sd32767, 16'sd32767);
  endtask

  task automatic test_extreme_square();
    send_beat(OP_APPEND, -16'sd32768, -16'sd32768);
    send_beat(OP_APPEND, 16'sd32767, -16'sd32768);
    send_beat(OP_APPEND, 16'sd32767, 16'sd32767);
    send_beat(OP_APPEND, -16'sd32768, 16'sd32767);
    send_beat(OP_QUERY, 16'sd0, 16'sd0);
    send_beat(OP_UNUSED, -16'sd1, -16'sd1);
    send_beat(OP_QUERY, -16'sd32768, 16'sd0);
    send_beat(OP_QUERY, 16'sd32767, 16'sd32767);
    send_beat(OP_QUERY, 16'sd0, -16'sd32768);
    send_beat(OP_QUERY, -16'sd32768, -16'sd32768);
    send_beat(OP_QUERY, 16'sd32767, 16'sd1);
    send_beat(OP_CLEAR, 16'sd0, 16'sd0);
    // triangle with a flat base; probe the apex, the base line and a point on a slanted edge
    send_beat(OP_APPEND, -16'sd4, 16'sd0);
    send_beat(OP_APPEND, 16'sd4, 16'sd0);
    send_beat(OP_APPEND, 16'sd0, 16'sd8);
    send_beat(OP_QUERY, 16'sd0, 16'sd8);
    send_beat(OP_QUERY, 16'sd1, 16'sd0);
    send_beat(OP_QUERY, 16'sd2, 16'sd4);
  endtask

  task automatic test_capacity();
    int i;
    send_beat(OP_CLEAR, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
    for (i = 0; i < MAX_VERTICES + 4; i++)
      send_beat(OP_APPEND, rand_coord(MODE_MID), rand_coord(MODE_MID));
    for (i = 0; i < 4; i++)
      send_beat(OP_QUERY, rand_coord(MODE_MID), rand_coord(MODE_MID));
    send_beat(OP_CLEAR, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
    send_beat(OP_QUERY, rand_coord(MODE_MID), rand_coord(MODE_MID));
  endtask

  task automatic run_polygon(input int n_vertices, input int n_queries, inout int beats);
    coord_t vx[$], vy[$];
    coord_t qx, qy;
    int mode, i, k;
    mode = $urandom_range(0, 3);
    send_beat(OP_CLEAR, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
    beats++;
    for (i = 0; i < n_vertices; i++) begin
      qx = rand_coord(mode);
      qy = rand_coord(mode);
      vx.push_back(qx);
      vy.push_back(qy);
      send_beat(OP_APPEND, qx, qy);
      beats++;
      if ($urandom_range(0, 19) == 0)
        send_beat(OP_UNUSED, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
      if ($urandom_range(0, 9) == 0) begin
        send_beat(OP_QUERY, rand_coord(mode), rand_coord(mode));
        beats++;
      end
    end
    for (i = 0; i < n_queries; i++) begin
      qx = rand_coord(mode);
      qy = rand_coord(mode);
      if (vx.size() != 0) begin
        k = $urandom_range(0, vx.size() - 1);
        case ($urandom_range(0, 3))
          0: qy = vy[k];
          1: begin
            qx = vx[k];
            qy = vy[k];
          end
          2: qx = rand_coord(MODE_FULL);
          default: ;
        endcase
      end
      send_beat(OP_QUERY, qx, qy);
      beats++;
    end
  endtask

  task automatic test_random_polygons();
    int beats, r, n;
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      r = $urandom_range(0, 19);
      if (r == 0) n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
      else if (r < 3) n = $urandom_range(0, 2);
      else n = $urandom_range(3, 12);
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      run_polygon(n, $urandom_range(2, 10), beats);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int i;
    int unused_beats;
    unused_beats = 0;
    sender_idles = 1'b0;
    run_polygon(6, 0, unused_beats);
    hold_off_cycles = HOLD_CYCLES;
    for (i = 0; i < 24; i++)
      send_beat(OP_QUERY, rand_coord(MODE_TINY), rand_coord(MODE_TINY));
    sender_idles = 1'b1;
  endtask

  task automatic test_sender_pause();
    int unused_beats;
    unused_beats = 0;
    run_polygon(5, 4, unused_beats);
    wait_drained();
    send_beat(OP_QUERY, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
    send_beat(OP_APPEND, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
    send_beat(OP_QUERY, rand_coord(MODE_FULL), rand_coord(MODE_FULL));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate_polygons();
    test_extreme_square();
    test_capacity();
    test_output_backpressure();
    test_sender_pause();
    test_random_polygons();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d queries: %0d inside, %0d on polygons under three vertices",
             queries_seen, inside_seen, degenerate_seen);
    $display("%0d appends past capacity and %0d unused-selector beats ignored, %0d mismatches",
             appends_dropped, ignored_beats, mismatch_count);
    if (mismatch_count == 0) begin
      $display("point_in_polygon_test regression: pass");
    end else begin
      $display("point_in_polygon_test regression: fail");
    end
    $finish;
  end

endmodule
